// ===== rtl/core/lomb_pkg.sv =====
// package for the limit order matching book: types and constants
package lomb_pkg;
    localparam int BOOK_ENTRIES_DEF = 64;
    localparam int ENTRY_W = 98;
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOID   = 2'd1;
    localparam logic [1:0] ST_TOOBIG = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;
    typedef enum logic [2:0] {
        t_CLEAR, t_IDLE, t_SCAN, t_MATCH, t_WRITE, t_DONE
    } t_state;
endpackage

// ===== rtl/core/lomb_mem.sv =====
// entry memory of the book: valid, side, price, quantity and id per slot
module lomb_mem
    import lomb_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);
    logic [ENTRY_W-1:0] r_mem [0:(1<<AW)-1];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/limit_order_matching_book.sv =====
// top level of the limit order matching book
// a scan reads every slot, then the match state applies the best match
// one scan for close and query, one scan per fill for an add plus one more unless the add
// ends filled; a zero add or unused action skips the scan and goes straight to write
// one item at a time, next item taken only once busy is low again; no receiver stall
// synchronous active-low reset, then a clearing pass empties every slot of the book, busy high
module limit_order_matching_book
    import lomb_pkg::*;
#(
    parameter int BOOK_ENTRIES = BOOK_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic [31:0] i_order_id,
    output logic        o_strobe,
    output logic [31:0] o_result_id,
    output logic [1:0]  o_status,
    output logic [31:0] o_filled_qty,
    output logic [31:0] o_entry_price,
    output logic [31:0] o_entry_qty,
    output logic [37:0] o_total_resting
);
    localparam int AW = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;

    t_state r_st, n_st;
    logic [AW:0]   r_ra;
    logic          r_rv;
    logic [AW-1:0] r_rslot;
    logic [1:0]  r_act;
    logic        r_side;
    logic [31:0] r_price, r_rem, r_oid, r_fill, r_nid;
    logic [37:0] r_sum;
    logic        r_found;
    logic [AW-1:0] r_best;
    logic        r_bside;
    logic [31:0] r_bprice, r_bqty, r_bid, r_bage;
    logic          r_free_ok;
    logic [AW-1:0] r_free;
    logic          we;
    logic [AW-1:0] waddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic          e_valid, e_side;
    logic [31:0]   e_price, e_qty, e_id, e_age;
    logic          cand, better;
    logic          rest;
    logic [1:0]    n_status;
    logic [31:0]   n_eprice, n_eqty;

    lomb_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_ra[AW-1:0]), .o_rdata(rdata)
    );

    assign {e_valid, e_side, e_price, e_qty, e_id} = rdata;
    assign e_age = r_nid - e_id;
    assign busy = (r_st != t_IDLE);
    assign rest = (r_act == ACT_ADD) && (r_rem != 32'd0) && r_free_ok;

    always_comb begin
        cand = 1'b0;
        better = 1'b0;
        if (r_rv && e_valid) begin
            if (r_act == ACT_ADD) begin
                cand = (e_side != r_side) &&
                       (r_side ? (e_price >= r_price) : (e_price <= r_price));
                better = !r_found ||
                         (r_side ? (e_price > r_bprice) : (e_price < r_bprice)) ||
                         (e_price == r_bprice && e_age > r_bage);
            end else begin
                cand = (e_id == r_oid);
                better = !r_found;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        we = 1'b0;
        waddr = r_best;
        wdata = {r_bqty > r_rem, r_bside, r_bprice, r_bqty - r_rem, r_bid};
        case (r_st)
            t_CLEAR: begin
                we = 1'b1;
                waddr = r_ra[AW-1:0];
                wdata = '0;
                if (r_ra == (AW+1)'(BOOK_ENTRIES - 1)) n_st = t_IDLE;
            end
            t_IDLE: if (start) begin
                if ((i_action == ACT_ADD && i_quantity == 32'd0) ||
                    !(i_action inside {ACT_ADD, ACT_CLOSE, ACT_QUERY})) n_st = t_WRITE;
                else n_st = t_SCAN;
            end
            t_SCAN: if (r_ra == (AW+1)'(BOOK_ENTRIES) && !r_rv) n_st = t_MATCH;
            t_MATCH: begin
                n_st = t_WRITE;
                if (r_act == ACT_ADD && r_found) begin
                    we = 1'b1;
                    if (r_bqty < r_rem) n_st = t_SCAN;
                end else if (r_act == ACT_CLOSE && r_found && r_rem <= r_bqty) begin
                    we = 1'b1;
                end
            end
            t_WRITE: begin
                n_st = t_DONE;
                if (rest) begin
                    we = 1'b1;
                    waddr = r_free;
                    wdata = {1'b1, r_side, r_price, r_rem, r_nid};
                end
            end
            t_DONE:  n_st = t_IDLE;
            default: n_st = t_IDLE;
        endcase
    end

    always_comb begin
        n_status = ST_OK;
        n_eprice = '0;
        n_eqty = '0;
        case (r_act)
            ACT_ADD: if (r_rem != 32'd0) begin
                if (r_free_ok) begin
                    n_eprice = r_price;
                    n_eqty = r_rem;
                end else n_status = ST_FULL;
            end
            ACT_CLOSE: if (!r_found) n_status = ST_NOID;
            else if (r_rem > r_bqty) begin
                n_status = ST_TOOBIG;
                n_eprice = r_bprice;
                n_eqty = r_bqty;
            end else begin
                n_eprice = r_bprice;
                n_eqty = r_bqty - r_rem;
            end
            ACT_QUERY: if (!r_found) n_status = ST_NOID;
            else begin
                n_eprice = r_bprice;
                n_eqty = r_bqty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= t_CLEAR;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= '0;
            r_nid <= '0;
            r_sum <= '0;
            r_rv <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (r_st == t_WRITE);
            r_rv <= (r_st == t_SCAN) && (r_ra != (AW+1)'(BOOK_ENTRIES));
            r_rslot <= r_ra[AW-1:0];
            case (r_st)
                t_CLEAR: r_ra <= r_ra + (AW+1)'(1);
                t_IDLE: if (start) begin
                    r_act <= i_action;
                    r_side <= i_side;
                    r_price <= i_price;
                    r_rem <= i_quantity;
                    r_oid <= i_order_id;
                    r_fill <= '0;
                    r_ra <= '0;
                    r_found <= 1'b0;
                    r_free_ok <= 1'b0;
                end
                t_SCAN: begin
                    if (r_ra != (AW+1)'(BOOK_ENTRIES)) r_ra <= r_ra + (AW+1)'(1);
                    if (cand && better) begin
                        r_found <= 1'b1;
                        r_best <= r_rslot;
                        r_bside <= e_side;
                        r_bprice <= e_price;
                        r_bqty <= e_qty;
                        r_bid <= e_id;
                        r_bage <= e_age;
                    end
                    if (r_rv && !e_valid && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free <= r_rslot;
                    end
                end
                t_MATCH: begin
                    if (n_st == t_SCAN) begin
                        r_ra <= '0;
                        r_found <= 1'b0;
                        r_free_ok <= 1'b0;
                    end
                    if (r_act == ACT_ADD && r_found) begin
                        if (r_bqty > r_rem) begin
                            r_fill <= r_fill + r_rem;
                            r_sum <= r_sum - {6'd0, r_rem};
                            r_rem <= '0;
                        end else begin
                            r_fill <= r_fill + r_bqty;
                            r_sum <= r_sum - {6'd0, r_bqty};
                            r_rem <= r_rem - r_bqty;
                        end
                    end else if (r_act == ACT_CLOSE && r_found && r_rem <= r_bqty) begin
                        r_sum <= r_sum - {6'd0, r_rem};
                    end
                end
                t_WRITE: begin
                    if (rest) r_sum <= r_sum + {6'd0, r_rem};
                    if (r_act == ACT_ADD) r_nid <= r_nid + 32'd1;
                    o_total_resting <= rest ? r_sum + {6'd0, r_rem} : r_sum;
                    o_result_id <= (r_act == ACT_ADD) ? r_nid : r_oid;
                    o_filled_qty <= (r_act == ACT_ADD) ? r_fill : 32'd0;
                    o_status <= n_status;
                    o_entry_price <= n_eprice;
                    o_entry_qty <= n_eqty;
                end
                default: ;
            endcase
        end
    end

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe longer than one cycle");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> !o_strobe) else $error("strobe while idle");
endmodule

// ===== dv/limit_order_matching_book_tb.sv =====
// testbench for the limit order matching book: directed and random orders checked by a scoreboard
`timescale 1ns / 1ps

module limit_order_matching_book_tb;
    import lomb_pkg::*;

    localparam int          SLOTS       = BOOK_ENTRIES_DEF;
    localparam logic [1:0]  ACT_NONE    = 2'd3;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          RAND_ITEMS  = 1930;

    typedef struct {
        logic [31:0] result_id;
        logic [1:0]  status;
        logic [31:0] filled_qty;
        logic [31:0] entry_price;
        logic [31:0] entry_qty;
        logic [37:0] total_resting;
    } t_book_result;

    class book_scoreboard;
        bit          live[SLOTS];
        bit          slot_sd[SLOTS];
        logic [31:0] slot_px[SLOTS];
        logic [31:0] slot_qt[SLOTS];
        logic [31:0] slot_id[SLOTS];
        logic [31:0] next_id;
        logic [37:0] resting;
        t_book_result expected_q[$];
        int errors;

        function new();
            foreach (live[i]) live[i] = 0;
            next_id = '0;
            resting = '0;
            errors  = 0;
        endfunction

        function int find_id(logic [31:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && slot_id[i] == id) return i;
            return -1;
        endfunction

        function int best_match(bit opp, logic [31:0] lim);
            int best;
            logic [31:0] bage, age;
            best = -1;
            bage = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!live[i] || slot_sd[i] != opp) continue;
                if (opp ? slot_px[i] > lim : slot_px[i] < lim) continue;
                age = next_id - slot_id[i];
                if (best < 0 ||
                    (opp ? slot_px[i] < slot_px[best] : slot_px[i] > slot_px[best]) ||
                    (slot_px[i] == slot_px[best] && age > bage)) begin
                    best = i;
                    bage = age;
                end
            end
            return best;
        endfunction

        function void note_item(logic [1:0] act, logic sd, logic [31:0] px,
                                logic [31:0] qt, logic [31:0] oid);
            t_book_result r;
            logic [31:0] rem;
            int s;
            r = '{oid, ST_OK, 32'd0, 32'd0, 32'd0, 38'd0};
            if (act == ACT_ADD) begin
                rem = qt;
                while (rem != 0) begin
                    s = best_match(!sd, px);
                    if (s < 0) break;
                    if (slot_qt[s] > rem) begin
                        slot_qt[s] -= rem;
                        r.filled_qty += rem;
                        resting -= rem;
                        rem = 0;
                    end else begin
                        r.filled_qty += slot_qt[s];
                        rem -= slot_qt[s];
                        resting -= slot_qt[s];
                        live[s] = 0;
                    end
                end
                if (rem != 0) begin
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!live[i]) begin
                            s = i;
                            break;
                        end
                    if (s < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        live[s]    = 1;
                        slot_sd[s] = sd;
                        slot_px[s] = px;
                        slot_qt[s] = rem;
                        slot_id[s] = next_id;
                        resting   += rem;
                        r.entry_price = px;
                        r.entry_qty   = rem;
                    end
                end
                r.result_id = next_id;
                next_id++;
            end else if (act == ACT_CLOSE || act == ACT_QUERY) begin
                s = find_id(oid);
                if (s < 0) begin
                    r.status = ST_NOID;
                end else begin
                    if (act == ACT_CLOSE) begin
                        if (qt > slot_qt[s]) begin
                            r.status = ST_TOOBIG;
                        end else begin
                            slot_qt[s] -= qt;
                            resting -= qt;
                            if (slot_qt[s] == 0) live[s] = 0;
                        end
                    end
                    r.entry_price = slot_px[s];
                    r.entry_qty   = slot_qt[s];
                end
            end
            r.total_resting = resting;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_book_result got);
            t_book_result e;
            if (expected_q.size() == 0) begin
                $error("result with no item outstanding, result_id %0h", got.result_id);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.result_id !== e.result_id) begin
                $error("result_id: expected %0h, actual %0h", e.result_id, got.result_id);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
            if (got.filled_qty !== e.filled_qty) begin
                $error("filled_qty: expected %0h, actual %0h", e.filled_qty, got.filled_qty);
                errors++;
            end
            if (got.entry_price !== e.entry_price) begin
                $error("entry_price: expected %0h, actual %0h", e.entry_price, got.entry_price);
                errors++;
            end
            if (got.entry_qty !== e.entry_qty) begin
                $error("entry_qty: expected %0h, actual %0h", e.entry_qty, got.entry_qty);
                errors++;
            end
            if (got.total_resting !== e.total_resting) begin
                $error("total_resting: expected %0h, actual %0h",
                       e.total_resting, got.total_resting);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_action = '0;
    logic        i_side = 0;
    logic [31:0] i_price = '0;
    logic [31:0] i_quantity = '0;
    logic [31:0] i_order_id = '0;
    logic        o_strobe;
    logic [31:0] o_result_id;
    logic [1:0]  o_status;
    logic [31:0] o_filled_qty;
    logic [31:0] o_entry_price;
    logic [31:0] o_entry_qty;
    logic [37:0] o_total_resting;
    int          cycles = 0;
    book_scoreboard sb = new();

    limit_order_matching_book u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_side(i_side), .i_price(i_price),
        .i_quantity(i_quantity), .i_order_id(i_order_id),
        .o_strobe(o_strobe), .o_result_id(o_result_id), .o_status(o_status),
        .o_filled_qty(o_filled_qty), .o_entry_price(o_entry_price),
        .o_entry_qty(o_entry_qty), .o_total_resting(o_total_resting)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result('{o_result_id, o_status, o_filled_qty, o_entry_price,
                              o_entry_qty, o_total_resting});
    end

    task automatic send_item(logic [1:0] act, logic sd, logic [31:0] px,
                             logic [31:0] qt, logic [31:0] oid);
        @(negedge i_clk);
        start      = 1;
        i_action   = act;
        i_side     = sd;
        i_price    = px;
        i_quantity = qt;
        i_order_id = oid;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_item(act, sd, px, qt, oid);
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            @(negedge i_clk);
            start = 0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) hold_off(0);
        else if (r < 92) hold_off($urandom_range(1, 3));
        else hold_off($urandom_range(5, 150));
    endtask

    task automatic drain();
        hold_off(1);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 85) return $urandom_range(1, 40);
        if (r < 95) return $urandom();
        return 32'hffff_ffff;
    endfunction

    function automatic logic [31:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(95, 110);
        if (r < 92) return 32'd0;
        if (r < 96) return 32'hffff_ffff;
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) < 8) return sb.next_id - $urandom_range(1, 90);
        return $urandom();
    endfunction

    // several mixes: normal trading, book filling, sweeping
    task automatic run_random(int n);
        int r, mode;
        logic [31:0] oid;
        for (int k = 0; k < n; k++) begin
            if (k % 150 == 0) mode = $urandom_range(0, 3);
            random_gap();
            if (k == n / 2) drain();
            r = $urandom_range(0, 99);
            if (mode == 1 && r < 85) begin
                send_item(ACT_ADD, $urandom_range(0, 1) ? 1'b1 : 1'b0,
                          $urandom_range(0, 1) ? 32'd10 : 32'd1000, pick_qty(), $urandom());
            end else if (mode == 2 && r < 15) begin
                send_item(ACT_ADD, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? 32'd0 : '1,
                          $urandom_range(0, 1) ? $urandom_range(50, 400) : '1, $urandom());
            end else if (r < 50) begin
                send_item(ACT_ADD, 1'($urandom_range(0, 1)), pick_price(), pick_qty(),
                          $urandom());
            end else if (r < 75) begin
                oid = pick_id();
                r = sb.find_id(oid);
                send_item(ACT_CLOSE, 1'($urandom_range(0, 1)), $urandom(),
                          (r >= 0 && $urandom_range(0, 3) != 0) ?
                              $urandom_range(0, sb.slot_qt[r]) : pick_qty(), oid);
            end else if (r < 97) begin
                send_item(ACT_QUERY, 1'($urandom_range(0, 1)), $urandom(), $urandom(),
                          pick_id());
            end else begin
                send_item(ACT_NONE, 1'($urandom_range(0, 1)), $urandom(), $urandom(),
                          $urandom());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        send_item(ACT_QUERY, 1'b0, 0, 0, 0);
        send_item(ACT_CLOSE, 1'b0, 0, 1, 5);
        send_item(ACT_ADD, 1'b0, 100, 0, 0);
        send_item(ACT_ADD, 1'b0, 100, 10, 0);
        send_item(ACT_ADD, 1'b0, 100, 5, 0);
        send_item(ACT_ADD, 1'b0, '1, '1, 0);
        send_item(ACT_ADD, 1'b1, 0, '1, 0);
        send_item(ACT_ADD, 1'b1, 100, 12, 0);
        send_item(ACT_ADD, 1'b1, 90, 10, 0);
        send_item(ACT_QUERY, 1'b0, 0, 0, 6);
        send_item(ACT_CLOSE, 1'b0, 0, 8, 6);
        send_item(ACT_CLOSE, 1'b0, 0, 0, 6);
        send_item(ACT_CLOSE, 1'b0, 0, 3, 6);
        send_item(ACT_CLOSE, 1'b0, 0, 4, 6);
        send_item(ACT_QUERY, 1'b0, 0, 0, 6);
        send_item(ACT_NONE, 1'b1, '1, '1, '1);
        send_item(ACT_ADD, 1'b1, 0, 1, 0);
        send_item(ACT_ADD, 1'b0, 0, 1, 0);
        send_item(ACT_ADD, 1'b1, 200, 3, 0);
        send_item(ACT_ADD, 1'b1, 200, 4, 0);
        send_item(ACT_ADD, 1'b0, 300, 20, 0);
        run_random(RAND_ITEMS);
        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
